[design/arq_receive_reorder_buffer_top_macros.svh]
// Assertion macros for the ARQ receive reorder buffer.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef ARQ_RECEIVE_REORDER_BUFFER_TOP_MACROS_SVH
`define ARQ_RECEIVE_REORDER_BUFFER_TOP_MACROS_SVH

`define ARQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ARQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/arq_rrb_pkg.sv]
// Shared types and constants of the ARQ receive reorder buffer.
// No dependencies.
package arq_rrb_pkg;
    localparam int DEPTH      = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int HANDLE_W   = 16;
    localparam int SEQ_W      = 8;
    localparam int NE_W       = 32;
    localparam int RND_W      = 25;
    localparam int SN_W       = 34;
    localparam int WIN_W      = 7;
    localparam int WAIT_W     = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [SEQ_W-1:0] RAW_LAST = 8'd254;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT   = 1'b1;
    localparam logic KIND_ACK     = 1'b0;
    localparam logic KIND_DELIVER = 1'b1;
    localparam logic ACT_PDU      = 1'b0;
    localparam logic ACT_TICK     = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ROUND, ST_SEQ, ST_CHECK, ST_GAP, ST_TICK, ST_REL, ST_FLUSH
    } t_state;

    typedef struct packed {
        logic ld_round;
        logic ld_sn;
        logic ack;
        logic gap_step;
        logic tick;
        logic rel_step;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic store_ok;
        logic sn_eq;
        logic gap_last;
        logic rel_go;
        logic rel_pdu;
        logic pend_valid;
        logic out_free;
    } t_stat;
endpackage

[design/arq_in_if.sv]
// Input channel of the ARQ receive reorder buffer.
// Depends on arq_rrb_pkg.
interface arq_in_if;
    logic                               valid;
    logic                               ready;
    logic                               action;
    logic [arq_rrb_pkg::SEQ_W-1:0]      seq_number;
    logic [arq_rrb_pkg::HANDLE_W-1:0]   pdu_handle;
    modport source (output valid, action, seq_number, pdu_handle, input ready);
    modport sink (input valid, action, seq_number, pdu_handle, output ready);
endinterface

[design/arq_out_if.sv]
// Result channel of the ARQ receive reorder buffer.
// Depends on arq_rrb_pkg.
interface arq_out_if;
    logic                               valid;
    logic                               ready;
    logic                               kind;
    logic [arq_rrb_pkg::SEQ_W-1:0]      ack_seq;
    logic                               dropped;
    logic [arq_rrb_pkg::HANDLE_W-1:0]   delivered_handle;
    logic [arq_rrb_pkg::NE_W-1:0]       global_seq;
    logic                               last;
    modport source (output valid, kind, ack_seq, dropped, delivered_handle, global_seq, last,
                    input ready);
    modport sink (input valid, kind, ack_seq, dropped, delivered_handle, global_seq, last,
                  output ready);
endinterface

[design/arq_rrb_ctrl.sv]
// Sequencer of the ARQ receive reorder buffer.
// Depends on arq_rrb_pkg; drives the datapath by command struct.
module arq_rrb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  arq_rrb_pkg::t_stat i_stat,
    output logic               o_in_ready,
    output arq_rrb_pkg::t_cmd  o_cmd
);
    arq_rrb_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= arq_rrb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            arq_rrb_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = arq_rrb_pkg::ST_ROUND;
            end
            arq_rrb_pkg::ST_ROUND: begin
                n_state = i_stat.is_tick ? arq_rrb_pkg::ST_TICK : arq_rrb_pkg::ST_SEQ;
            end
            arq_rrb_pkg::ST_SEQ: n_state = arq_rrb_pkg::ST_CHECK;
            arq_rrb_pkg::ST_CHECK: begin
                if (!i_stat.store_ok) n_state = arq_rrb_pkg::ST_FLUSH;
                else if (i_stat.sn_eq) n_state = arq_rrb_pkg::ST_REL;
                else n_state = arq_rrb_pkg::ST_GAP;
            end
            arq_rrb_pkg::ST_GAP: begin
                if (i_stat.gap_last) n_state = arq_rrb_pkg::ST_FLUSH;
            end
            arq_rrb_pkg::ST_TICK: n_state = arq_rrb_pkg::ST_REL;
            arq_rrb_pkg::ST_REL: begin
                if (!i_stat.rel_go) n_state = arq_rrb_pkg::ST_FLUSH;
            end
            arq_rrb_pkg::ST_FLUSH: begin
                if (!i_stat.pend_valid || i_stat.out_free) n_state = arq_rrb_pkg::ST_IDLE;
            end
            default: n_state = arq_rrb_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            arq_rrb_pkg::ST_IDLE:  o_in_ready = 1'b1;
            arq_rrb_pkg::ST_ROUND: o_cmd.ld_round = 1'b1;
            arq_rrb_pkg::ST_SEQ:   o_cmd.ld_sn = 1'b1;
            arq_rrb_pkg::ST_CHECK: o_cmd.ack = 1'b1;
            arq_rrb_pkg::ST_GAP:   o_cmd.gap_step = 1'b1;
            arq_rrb_pkg::ST_TICK:  o_cmd.tick = 1'b1;
            arq_rrb_pkg::ST_REL: begin
                o_cmd.rel_step = i_stat.rel_go &&
                    !(i_stat.rel_pdu && i_stat.pend_valid && !i_stat.out_free);
            end
            arq_rrb_pkg::ST_FLUSH: o_cmd.flush = i_stat.pend_valid && i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end
endmodule

[design/arq_rrb_dp.sv]
// Datapath of the ARQ receive reorder buffer: sequence state, slots, timers, results.
// Depends on arq_rrb_pkg, arq_in_if and arq_out_if.
module arq_rrb_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [arq_rrb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [arq_rrb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                                i_in_ready,
    input  arq_rrb_pkg::t_cmd                   i_cmd,
    output arq_rrb_pkg::t_stat                  o_stat,
    arq_in_if.sink                              in_ch,
    arq_out_if.source                           out_ch
);
    localparam int IW = arq_rrb_pkg::IDX_W;
    localparam int SW = arq_rrb_pkg::SN_W;

    logic [arq_rrb_pkg::WIN_W-1:0]    r_win;
    logic [arq_rrb_pkg::WAIT_W-1:0]   r_wait;
    logic [arq_rrb_pkg::NE_W-1:0]     r_ne;
    logic [arq_rrb_pkg::RND_W-1:0]    r_rounds;
    logic [arq_rrb_pkg::SEQ_W-1:0]    r_raw;
    logic [arq_rrb_pkg::DEPTH-1:0]    r_present, r_ready, r_pdu;
    logic [arq_rrb_pkg::HANDLE_W-1:0] r_handle [arq_rrb_pkg::DEPTH];
    logic [arq_rrb_pkg::WAIT_W-1:0]   r_timer [arq_rrb_pkg::DEPTH];
    logic                             r_act;
    logic [arq_rrb_pkg::SEQ_W-1:0]    r_seq;
    logic [arq_rrb_pkg::HANDLE_W-1:0] r_hdl;
    logic [arq_rrb_pkg::RND_W-1:0]    r_adj;
    logic                             r_under;
    logic [SW-1:0]                    r_sn;
    logic [IW-1:0]                    r_cnt;
    logic                             r_pv;
    logic                             r_pkind, r_pdrop;
    logic [arq_rrb_pkg::SEQ_W-1:0]    r_pseq;
    logic [arq_rrb_pkg::HANDLE_W-1:0] r_phdl;
    logic [arq_rrb_pkg::NE_W-1:0]     r_pgs;
    logic                             r_ov;

    logic [arq_rrb_pkg::SEQ_W:0] guard;
    logic [arq_rrb_pkg::SEQ_W-1:0] d_up, d_dn;
    logic [SW-1:0] ne_x, diff;
    logic drop, store_ok, out_free, push;
    logic [IW-1:0] sidx, gidx, rel_idx;

    assign guard    = {1'b0, r_win, 1'b0};
    assign d_up     = r_seq - r_raw;
    assign d_dn     = r_raw - r_seq;
    assign ne_x     = {{(SW - arq_rrb_pkg::NE_W){1'b0}}, r_ne};
    assign diff     = r_sn - ne_x;
    assign drop     = r_under || (r_sn >= ne_x && diff[SW-1:IW] != '0);
    assign store_ok = !drop && r_sn >= ne_x;
    assign sidx     = r_sn[IW-1:0];
    assign gidx     = r_ne[IW-1:0] + r_cnt;
    assign rel_idx  = r_ne[IW-1:0];
    assign out_free = !r_ov || out_ch.ready;
    assign push     = (i_cmd.rel_step && r_pdu[rel_idx] && r_pv) || i_cmd.flush;

    assign o_stat.is_tick    = (r_act == arq_rrb_pkg::ACT_TICK);
    assign o_stat.store_ok   = store_ok;
    assign o_stat.sn_eq      = (diff == '0);
    assign o_stat.gap_last   = (r_cnt + 1'b1) == diff[IW-1:0];
    assign o_stat.rel_go     = r_present[rel_idx] && r_ready[rel_idx];
    assign o_stat.rel_pdu    = r_pdu[rel_idx];
    assign o_stat.pend_valid = r_pv;
    assign o_stat.out_free   = out_free;

    assign in_ch.ready = i_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= 7'd10;
            r_wait <= 16'd1800;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                arq_rrb_pkg::CFG_WINDOW: r_win <= i_cfg_data[arq_rrb_pkg::WIN_W-1:0];
                arq_rrb_pkg::CFG_WAIT:   r_wait <= i_cfg_data[arq_rrb_pkg::WAIT_W-1:0];
                default: ;
            endcase
        end
    end

    // input capture and sequence widening
    always_ff @(posedge i_clk) begin
        if (in_ch.valid && i_in_ready) begin
            r_act <= in_ch.action;
            r_seq <= in_ch.seq_number;
            r_hdl <= in_ch.pdu_handle;
        end
        if (i_cmd.ld_round) begin
            r_adj   <= r_rounds;
            r_under <= 1'b0;
            if (r_seq >= r_raw) begin
                if ({1'b0, d_up} > guard) begin
                    if (r_rounds == '0) r_under <= 1'b1;
                    else r_adj <= r_rounds - 1'b1;
                end
            end else if ({1'b0, d_dn} > guard) begin
                r_adj <= r_rounds + 1'b1;
            end
        end
        if (i_cmd.ld_sn) begin
            r_sn <= ({1'b0, r_adj, 8'd0} - {{(SW - arq_rrb_pkg::RND_W){1'b0}}, r_adj})
                    + {{(SW - arq_rrb_pkg::SEQ_W){1'b0}}, r_seq};
        end
        if (i_cmd.ack) r_cnt <= '0;
        else if (i_cmd.gap_step) r_cnt <= r_cnt + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ack && store_ok) r_handle[sidx] <= r_hdl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ne      <= '0;
            r_rounds  <= '0;
            r_raw     <= '0;
            r_present <= '0;
            r_ready   <= '0;
            r_pdu     <= '0;
            for (int i = 0; i < arq_rrb_pkg::DEPTH; i++) r_timer[i] <= '0;
        end else begin
            if (i_cmd.ack && store_ok) begin
                r_present[sidx] <= 1'b1;
                r_ready[sidx]   <= 1'b1;
                r_pdu[sidx]     <= 1'b1;
                r_timer[sidx]   <= '0;
            end
            if (i_cmd.gap_step && !r_present[gidx]) begin
                r_present[gidx] <= 1'b1;
                r_ready[gidx]   <= 1'b0;
                r_pdu[gidx]     <= 1'b0;
                r_timer[gidx]   <= r_wait;
            end
            if (i_cmd.tick) begin
                for (int i = 0; i < arq_rrb_pkg::DEPTH; i++) begin
                    if (r_present[i] && !r_ready[i]) begin
                        if (r_timer[i] <= 16'd1) begin
                            r_timer[i] <= '0;
                            r_ready[i] <= 1'b1;
                        end else begin
                            r_timer[i] <= r_timer[i] - 1'b1;
                        end
                    end
                end
            end
            if (i_cmd.rel_step) begin
                r_present[rel_idx] <= 1'b0;
                r_ready[rel_idx]   <= 1'b0;
                r_pdu[rel_idx]     <= 1'b0;
                r_timer[rel_idx]   <= '0;
                r_ne <= r_ne + 1'b1;
                if (r_ne == '1) begin
                    r_rounds <= '0;
                    r_raw    <= '0;
                end else if (r_raw == arq_rrb_pkg::RAW_LAST) begin
                    r_raw    <= '0;
                    r_rounds <= r_rounds + 1'b1;
                end else begin
                    r_raw <= r_raw + 1'b1;
                end
            end
        end
    end

    // pending result and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (push) r_ov <= 1'b1;
            else if (out_ch.ready) r_ov <= 1'b0;
            if (i_cmd.ack || (i_cmd.rel_step && r_pdu[rel_idx])) r_pv <= 1'b1;
            else if (i_cmd.flush) r_pv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            out_ch.kind             <= r_pkind;
            out_ch.ack_seq          <= r_pseq;
            out_ch.dropped          <= r_pdrop;
            out_ch.delivered_handle <= r_phdl;
            out_ch.global_seq       <= r_pgs;
            out_ch.last             <= i_cmd.flush;
        end
        if (i_cmd.ack) begin
            r_pkind <= arq_rrb_pkg::KIND_ACK;
            r_pseq  <= r_seq;
            r_pdrop <= drop;
            r_phdl  <= '0;
            r_pgs   <= '0;
        end else if (i_cmd.rel_step && r_pdu[rel_idx]) begin
            r_pkind <= arq_rrb_pkg::KIND_DELIVER;
            r_pseq  <= '0;
            r_pdrop <= 1'b0;
            r_phdl  <= r_handle[rel_idx];
            r_pgs   <= r_ne;
        end
    end

    assign out_ch.valid = r_ov;
endmodule

[design/arq_receive_reorder_buffer_top.sv]
// Top level of the ARQ receive reorder buffer: sequencer plus datapath.
// Depends on arq_rrb_pkg, arq_in_if, arq_out_if, arq_rrb_ctrl, arq_rrb_dp.
// Arrival: ROUND, SEQ and CHECK states, then a GAP step per gap slot filled, before the ACK beat is output.
// Tick: ROUND and TICK states, then REL releases slots in order (up to 32).
// One item at a time: input is ready only in IDLE; the slot walk makes the longest items.
// Synchronous reset clears all slots, next expected to zero, config registers to defaults.
`include "arq_receive_reorder_buffer_top_macros.svh"
module arq_receive_reorder_buffer_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [arq_rrb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [arq_rrb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    arq_in_if.sink                              in_ch,
    arq_out_if.source                           out_ch
);
    arq_rrb_pkg::t_cmd  cmd;
    arq_rrb_pkg::t_stat stat;
    logic               in_ready;

    arq_rrb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    arq_rrb_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_ready (in_ready),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .in_ch      (in_ch),
        .out_ch     (out_ch)
    );

    `ARQ_ASSERT_IMP(a_idle_no_pending, in_ready, !stat.pend_valid, "pending beat while idle")
    `ARQ_ASSERT_IMP(a_deliver_clean, out_ch.valid && out_ch.kind == arq_rrb_pkg::KIND_DELIVER, out_ch.ack_seq == '0 && !out_ch.dropped, "delivery beat carries ack fields")
    `ARQ_ASSERT_NXT(a_flush_last, cmd.flush, out_ch.valid && out_ch.last, "flushed beat not marked last")
endmodule

[sim/tb_arq_receive_reorder_buffer_top.sv]
// Self-checking testbench for arq_receive_reorder_buffer_top: random PDU arrivals and ticks,
// results checked against an in-bench reorder buffer predictor.
// Depends on arq_rrb_pkg, arq_in_if, arq_out_if and the RTL under design/.
module tb_arq_receive_reorder_buffer_top;
    import arq_rrb_pkg::*;

    typedef struct packed {
        logic                kind;
        logic [SEQ_W-1:0]    ack_seq;
        logic                dropped;
        logic [HANDLE_W-1:0] hdl;
        logic [NE_W-1:0]     gseq;
        logic                last;
    } t_result;

    typedef struct packed {
        logic                action;
        logic [SEQ_W-1:0]    seq;
        logic [HANDLE_W-1:0] hdl;
    } t_arrival;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    arq_in_if  in_ch();
    arq_out_if out_ch();

    arq_receive_reorder_buffer_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch)
    );

    // predictor state
    logic [WIN_W-1:0]    win_size;
    logic [WAIT_W-1:0]   wait_ticks;
    logic [NE_W-1:0]     next_exp;
    logic                sl_present [DEPTH];
    logic                sl_ready   [DEPTH];
    logic                sl_has_pdu [DEPTH];
    logic [HANDLE_W-1:0] sl_handle  [DEPTH];
    logic [WAIT_W-1:0]   sl_timer   [DEPTH];

    t_arrival pending_q[$];
    t_result  result_q[$];
    t_arrival cur;
    int       errors;
    int       send_idle;
    int       recv_idle;
    int       hold_cnt;
    bit       hold_start;
    bit       hold_done;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    task automatic clear_slot(input int s);
        sl_present[s] = 1'b0;
        sl_ready[s]   = 1'b0;
        sl_has_pdu[s] = 1'b0;
        sl_handle[s]  = '0;
        sl_timer[s]   = '0;
    endtask

    task automatic release_in_order();
        int s;
        t_result r;
        for (int n = 0; n < DEPTH; n++) begin
            s = next_exp % DEPTH;
            if (!sl_present[s] || !sl_ready[s]) break;
            if (sl_has_pdu[s]) begin
                r = '{kind: KIND_DELIVER, ack_seq: '0, dropped: 1'b0,
                      hdl: sl_handle[s], gseq: next_exp, last: 1'b0};
                result_q.push_back(r);
            end
            clear_slot(s);
            next_exp = next_exp + 1;
        end
    endtask

    task automatic predict_beat(input t_arrival a);
        longint unsigned rounds;
        longint unsigned sn;
        longint unsigned ne;
        longint unsigned guard;
        longint unsigned raw;
        longint unsigned sq;
        bit drop;
        int first;
        int s;
        t_result r;
        first = result_q.size();
        if (a.action == ACT_PDU) begin
            ne     = next_exp;
            guard  = 2 * win_size;
            rounds = ne / 255;
            raw    = ne % 255;
            sq     = a.seq;
            drop   = 1'b0;
            if (sq >= raw) begin
                if (sq - raw > guard) begin
                    if (rounds == 0) drop = 1'b1;
                    else rounds--;
                end
            end else if (raw - sq > guard) begin
                rounds++;
            end
            sn = rounds * 255 + sq;
            if (!drop && sn >= ne && sn - ne >= DEPTH) drop = 1'b1;
            r = '{kind: KIND_ACK, ack_seq: a.seq, dropped: drop, hdl: '0, gseq: '0, last: 1'b0};
            result_q.push_back(r);
            if (!drop && sn >= ne) begin
                s = sn % DEPTH;
                sl_present[s] = 1'b1;
                sl_ready[s]   = 1'b1;
                sl_has_pdu[s] = 1'b1;
                sl_handle[s]  = a.hdl;
                sl_timer[s]   = '0;
                if (sn != ne) begin
                    for (longint unsigned i = ne; i < sn; i++) begin
                        s = i % DEPTH;
                        if (!sl_present[s]) begin
                            sl_present[s] = 1'b1;
                            sl_ready[s]   = 1'b0;
                            sl_has_pdu[s] = 1'b0;
                            sl_timer[s]   = wait_ticks;
                        end
                    end
                end else begin
                    release_in_order();
                end
            end
        end else begin
            for (int k = 0; k < DEPTH; k++) begin
                if (sl_present[k] && !sl_ready[k]) begin
                    if (sl_timer[k] <= 1) begin
                        sl_timer[k] = '0;
                        sl_ready[k] = 1'b1;
                    end else begin
                        sl_timer[k] = sl_timer[k] - 1;
                    end
                end
            end
            release_in_order();
        end
        if (result_q.size() > first) result_q[$].last = 1'b1;
    endtask

    // driver
    always @(posedge i_clk) begin
        logic nv;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            nv = in_ch.valid;
            if (in_ch.valid && in_ch.ready) begin
                predict_beat(cur);
                nv = 1'b0;
            end
            if (!nv && pending_q.size() != 0 && $urandom_range(99) >= send_idle) begin
                cur = pending_q.pop_front();
                in_ch.action     <= cur.action;
                in_ch.seq_number <= cur.seq;
                in_ch.pdu_handle <= cur.hdl;
                nv = 1'b1;
            end
            in_ch.valid <= nv;
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (hold_start && !hold_done) begin
            hold_cnt  <= 400;
            hold_done <= 1'b1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = '{kind: out_ch.kind, ack_seq: out_ch.ack_seq, dropped: out_ch.dropped,
                        hdl: out_ch.delivered_handle, gseq: out_ch.global_seq,
                        last: out_ch.last};
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected beat %p", $time, got);
                    errors++;
                end else begin
                    want = result_q.pop_front();
                    if (got.kind !== want.kind || got.ack_seq !== want.ack_seq ||
                        got.dropped !== want.dropped || got.hdl !== want.hdl ||
                        got.gseq !== want.gseq || got.last !== want.last) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                        errors++;
                    end
                end
            end
            out_ch.ready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic add_item(input logic act, input logic [SEQ_W-1:0] seq,
                            input logic [HANDLE_W-1:0] hdl);
        t_arrival a;
        a = '{action: act, seq: seq, hdl: hdl};
        pending_q.push_back(a);
    endtask

    task automatic drain();
        while (pending_q.size() != 0 || in_ch.valid || result_q.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_WINDOW) win_size = val[WIN_W-1:0];
        else wait_ticks = val[WAIT_W-1:0];
    endtask

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int base;
        int cfg_win  [5];
        int cfg_wait [5];
        cfg_win  = '{1, 127, 10, 64, 3};
        cfg_wait = '{1, 65535, 5, 2, 3};
        errors = 0; send_idle = 6; recv_idle = 66;
        hold_cnt = 0; hold_start = 1'b0; hold_done = 1'b0;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = CFG_WINDOW; i_cfg_data = '0;
        in_ch.valid = 1'b0; in_ch.action = ACT_PDU; in_ch.seq_number = '0;
        in_ch.pdu_handle = '0; out_ch.ready = 1'b0;
        win_size = 7'd10; wait_ticks = 16'd1800; next_exp = '0;
        for (int s = 0; s < DEPTH; s++) clear_slot(s);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: round underflow at reset state, in-order, gap fill, beyond depth,
        // duplicate, stale arrival, timer expiry, idle tick
        add_item(ACT_PDU, 8'd255, 16'h1234);
        add_item(ACT_PDU, 8'd0, 16'h0000);
        add_item(ACT_PDU, 8'd2, 16'hFFFF);
        add_item(ACT_PDU, 8'd1, 16'h00FF);
        add_item(ACT_TICK, 8'd0, 16'h0);
        drain();
        write_cfg(CFG_WINDOW, 127);
        write_cfg(CFG_WAIT, 3);
        add_item(ACT_PDU, 8'd40, 16'hA5A5);
        add_item(ACT_PDU, 8'd6, 16'h5A5A);
        add_item(ACT_PDU, 8'd6, 16'hC3C3);
        add_item(ACT_PDU, 8'd34, 16'h8001);
        add_item(ACT_PDU, 8'd0, 16'h7FFE);
        for (int i = 0; i < 4; i++) add_item(ACT_TICK, 8'd0, 16'h0);
        add_item(ACT_PDU, 8'd4, 16'h4444);
        for (int i = 0; i < 4; i++) add_item(ACT_TICK, 8'd0, 16'h0);
        drain();
        base = 35;

        for (int ph = 0; ph < 5; ph++) begin
            write_cfg(CFG_WINDOW, cfg_win[ph]);
            write_cfg(CFG_WAIT, cfg_wait[ph]);
            if (ph < 2) begin
                send_idle = 6; recv_idle = 66;
            end else if (ph < 4) begin
                send_idle = 66; recv_idle = 6;
            end else begin
                send_idle = 0; recv_idle = 0;
            end
            if (ph == 2) hold_start = 1'b1;
            for (int i = 0; i < 26; i++) begin
                int r;
                r = $urandom_range(99);
                if (r < 25) begin
                    add_item(ACT_TICK, SEQ_W'($urandom_range(255)),
                             HANDLE_W'($urandom_range(65535)));
                end else if (r < 35) begin
                    add_item(ACT_PDU, SEQ_W'($urandom_range(255)),
                             HANDLE_W'($urandom_range(65535)));
                end else begin
                    add_item(ACT_PDU, SEQ_W'((base + $urandom_range(12)) % 255),
                             HANDLE_W'($urandom_range(65535)));
                    base += $urandom_range(3);
                end
            end
            drain();
        end

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

[sim.f]
+incdir+design
design/arq_rrb_pkg.sv
design/arq_in_if.sv
design/arq_out_if.sv
design/arq_rrb_ctrl.sv
design/arq_rrb_dp.sv
design/arq_receive_reorder_buffer_top.sv
sim/tb_arq_receive_reorder_buffer_top.sv
